[hdl/k2hid_pkg.sv]
`timescale 1ns / 1ps

package k2hid_pkg;

	localparam logic [7:0] LshiftBit  = 8'h02;
	localparam logic [7:0] BothShifts = 8'h22;
	localparam logic [7:0] NoUsage    = 8'h00;

	function automatic logic [7:0] modifier_of(input logic [31:0] k);
		logic [7:0] m;
		begin
			m = 8'h00;
			unique case (k)
				32'hFFE3: m = 8'h01;
				32'hFFE1: m = 8'h02;
				32'hFFE9: m = 8'h04;
				32'hFFE7: m = 8'h08;
				32'hFFE4: m = 8'h10;
				32'hFFE2: m = 8'h20;
				32'hFFEA: m = 8'h40;
				32'hFFE8: m = 8'h80;
				32'h21, 32'h40, 32'h23, 32'h24, 32'h25,
				32'h5E, 32'h26, 32'h2A, 32'h28, 32'h29,
				32'h5F, 32'h2B, 32'h7B, 32'h7D, 32'h7C,
				32'h3A, 32'h22, 32'h7E, 32'h3C, 32'h3E,
				32'h3F: m = LshiftBit;
				default: m = 8'h00;
			endcase
			if (k >= 32'h41 && k <= 32'h5A) begin
				m = LshiftBit;
			end
			return m;
		end
	endfunction

	function automatic logic [7:0] usage_of(input logic [31:0] k);
		logic [31:0] kl;
		logic [7:0]  u;
		begin
			kl = k;
			if (k >= 32'h41 && k <= 32'h5A) begin
				kl = k | 32'h20;
			end
			u = NoUsage;
			if (kl >= 32'h61 && kl <= 32'h7A) begin
				u = 8'h04 + 8'(kl - 32'h61);
			end else if (kl >= 32'h31 && kl <= 32'h39) begin
				u = 8'h1E + 8'(kl - 32'h31);
			end else if (kl >= 32'hFFBE && kl <= 32'hFFCA) begin
				u = 8'h3A + 8'(kl - 32'hFFBE);
			end else if (kl >= 32'hFFB1 && kl <= 32'hFFB9) begin
				u = 8'h59 + 8'(kl - 32'hFFB1);
			end else begin
				unique case (kl)
					32'h21: u = 8'h1E;
					32'h40: u = 8'h1F;
					32'h23: u = 8'h20;
					32'h24: u = 8'h21;
					32'h25: u = 8'h22;
					32'h5E: u = 8'h23;
					32'h26: u = 8'h24;
					32'h2A: u = 8'h25;
					32'h28: u = 8'h26;
					32'h30, 32'h29: u = 8'h27;
					32'hFF0D: u = 8'h28;
					32'hFF1B: u = 8'h29;
					32'hFF08: u = 8'h2A;
					32'hFF09: u = 8'h2B;
					32'h20: u = 8'h2C;
					32'h2D, 32'h5F: u = 8'h2D;
					32'h3D, 32'h2B: u = 8'h2E;
					32'h5B, 32'h7B: u = 8'h2F;
					32'h5D, 32'h7D: u = 8'h30;
					32'h5C, 32'h7C: u = 8'h31;
					32'h3B, 32'h3A: u = 8'h33;
					32'h27, 32'h22: u = 8'h34;
					32'h60, 32'h7E: u = 8'h35;
					32'h2C, 32'h3C: u = 8'h36;
					32'h2E, 32'h3E: u = 8'h37;
					32'h2F, 32'h3F: u = 8'h38;
					32'hFF02: u = 8'h48;
					32'hFF6A: u = 8'h49;
					32'hFF50: u = 8'h4A;
					32'hFF55: u = 8'h4B;
					32'hFFFF: u = 8'h4C;
					32'hFF57: u = 8'h4D;
					32'hFF56: u = 8'h4E;
					32'hFF53: u = 8'h4F;
					32'hFF51: u = 8'h50;
					32'hFF54: u = 8'h51;
					32'hFF52: u = 8'h52;
					32'hFFAF: u = 8'h54;
					32'hFFAA: u = 8'h55;
					32'hFFAD: u = 8'h56;
					32'hFFAB: u = 8'h57;
					32'hFF8D: u = 8'h58;
					32'hFFB0: u = 8'h62;
					32'hFFAE: u = 8'h63;
					default: u = NoUsage;
				endcase
			end
			return u;
		end
	endfunction

endpackage

[hdl/k2hid_slots.sv]
`timescale 1ns / 1ps

module k2hid_slots #(
	parameter int KEY_SLOTS = 6
) (
	input  logic                      key_pressed,
	input  logic [31:0]               keysym,
	input  logic [7:0]                mods,
	input  logic [KEY_SLOTS-1:0][7:0] slots,
	output logic [7:0]                mods_n,
	output logic [KEY_SLOTS-1:0][7:0] slots_n,
	output logic                      changed
);
	import k2hid_pkg::*;

	logic [7:0]                m;
	logic [7:0]                u;
	logic [KEY_SLOTS-1:0][7:0] slots_a;
	logic                      present;
	logic                      placed;

	always_comb begin
		m       = modifier_of(keysym);
		u       = usage_of(keysym);
		mods_n  = mods;
		slots_a = slots;
		if (m != 8'h00) begin
			if (key_pressed) begin
				mods_n = mods | m;
				if ((mods_n & BothShifts) == BothShifts) begin
					mods_n  = 8'h00;
					slots_a = '0;
				end
			end else begin
				mods_n = mods & ~m;
			end
		end

		present = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (slots_a[i] == u) begin
				present = 1'b1;
			end
		end

		slots_n = slots_a;
		placed  = 1'b0;
		if (u != NoUsage) begin
			if (key_pressed) begin
				if (!present) begin
					for (int i = 0; i < KEY_SLOTS; i++) begin
						if (!placed && slots_a[i] == NoUsage) begin
							slots_n[i] = u;
							placed     = 1'b1;
						end
					end
				end
			end else begin
				for (int i = 0; i < KEY_SLOTS; i++) begin
					if (slots_a[i] == u) begin
						slots_n[i] = NoUsage;
					end
				end
			end
		end

		changed = (mods_n != mods) || (slots_n != slots);
	end

endmodule

[hdl/keysym_to_hid_keyboard_report.sv]
`timescale 1ns / 1ps
// Channel  | Handshake            | Beat
// input    | in_valid / in_ready  | key_pressed, keysym
// output   | out_valid / out_ready| modifier_bits, first_key_code
//
// One key event per cycle sustained while the output is not stalled. A beat is held
// in the input register, where decode and slot update run against the report,
// then lands in the output register when the report changed (else it is dropped).
// Reset clears the report and all valid flags.
// A stalled output holds the input register; in_ready stays high while it
// can drain the same cycle.

module keysym_to_hid_keyboard_report #(
	parameter int KEY_SLOTS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        key_pressed,
	input  logic [31:0] keysym,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  modifier_bits,
	output logic [7:0]  first_key_code
);
	import k2hid_pkg::*;

	logic                      valid_s1;
	logic                      key_pressed_s1;
	logic [31:0]               keysym_s1;
	logic [7:0]                mods_q;
	logic [KEY_SLOTS-1:0][7:0] slots_q;
	logic [7:0]                mods_n;
	logic [KEY_SLOTS-1:0][7:0] slots_n;
	logic                      changed;
	logic                      advance;
	logic                      out_valid_q;
	logic [7:0]                modifier_bits_q;
	logic [7:0]                first_key_code_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	k2hid_slots #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_slots (
		.key_pressed(key_pressed_s1),
		.keysym     (keysym_s1),
		.mods       (mods_q),
		.slots      (slots_q),
		.mods_n     (mods_n),
		.slots_n    (slots_n),
		.changed    (changed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			mods_q      <= 8'h00;
			slots_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				mods_q  <= mods_n;
				slots_q <= slots_n;
			end
			if (advance && changed) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_pressed_s1 <= key_pressed;
			keysym_s1      <= keysym;
		end
		if (advance && changed) begin
			modifier_bits_q  <= mods_n;
			first_key_code_q <= slots_n[0];
		end
	end

	assign out_valid      = out_valid_q;
	assign modifier_bits  = modifier_bits_q;
	assign first_key_code = first_key_code_q;

endmodule

[hdl/k2hid_checker.sv]
`timescale 1ns / 1ps

module k2hid_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] modifier_bits,
	input logic [7:0] first_key_code
);
	import k2hid_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(modifier_bits)
			&& $stable(first_key_code))
		else $error("output beat changed while stalled");

	a_no_both_shifts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (modifier_bits & BothShifts) != BothShifts)
		else $error("both shifts reported together");

	a_key_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> first_key_code <= 8'h63 && first_key_code != 8'h01
			&& first_key_code != 8'h02 && first_key_code != 8'h03)
		else $error("first key code is not a mapped usage");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind keysym_to_hid_keyboard_report k2hid_checker u_k2hid_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.modifier_bits (modifier_bits),
	.first_key_code(first_key_code)
);

[bench/keysym_to_hid_keyboard_report_check.sv]
`timescale 1ns / 1ps

module keysym_to_hid_keyboard_report_check #(
	parameter int KEY_SLOTS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        key_pressed,
	input  logic [31:0] keysym,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  modifier_bits,
	input  logic [7:0]  first_key_code,
	output int          fail_count,
	output int          open_count
);

	import k2hid_pkg::BothShifts;
	import k2hid_pkg::LshiftBit;

	typedef struct packed {
		logic [7:0] mods;
		logic [7:0] first_code;
	} hid_report_t;

	hid_report_t                 pending_reports[$];
	logic [7:0]                  held_mods = 8'h00;
	logic [KEY_SLOTS-1:0][7:0]   held_slots = '0;
	int                          error_total = 0;
	int                          pending_total = 0;

	assign fail_count = error_total;
	assign open_count = pending_total;

	function automatic logic [7:0] modifier_mask_for(input logic [31:0] k);
		logic [7:0] mask;
		mask = 8'h00;
		if (k[31:8] == 24'h0000FF && k[7:4] == 4'hE) begin
			case (k[3:0])
				4'h1: mask = 8'h02;
				4'h2: mask = 8'h20;
				4'h3: mask = 8'h01;
				4'h4: mask = 8'h10;
				4'h7: mask = 8'h08;
				4'h8: mask = 8'h80;
				4'h9: mask = 8'h04;
				4'hA: mask = 8'h40;
				default: mask = 8'h00;
			endcase
		end else if (k >= 32'h41 && k <= 32'h5A) begin
			mask = LshiftBit;
		end else begin
			case (k)
				32'h21, 32'h22, 32'h23, 32'h24, 32'h25, 32'h26, 32'h28,
				32'h29, 32'h2A, 32'h2B, 32'h3A, 32'h3C, 32'h3E, 32'h3F,
				32'h40, 32'h5E, 32'h5F, 32'h7B, 32'h7C, 32'h7D, 32'h7E:
					mask = LshiftBit;
				default: mask = 8'h00;
			endcase
		end
		return mask;
	endfunction

	function automatic logic [7:0] hid_usage_for(input logic [31:0] k);
		logic [31:0] c;
		logic [31:0] off;
		logic [7:0]  code;
		c = k;
		if (k >= 32'h41 && k <= 32'h5A)
			c = k | 32'h20;
		code = 8'h00;
		if (c >= 32'h61 && c <= 32'h7A) begin
			off = c - 32'h61;
			code = off[7:0] + 8'h04;
		end else if (c >= 32'h31 && c <= 32'h39) begin
			off = c - 32'h31;
			code = off[7:0] + 8'h1E;
		end else if (c >= 32'hFFBE && c <= 32'hFFCA) begin
			off = c - 32'hFFBE;
			code = off[7:0] + 8'h3A;
		end else if (c >= 32'hFFB1 && c <= 32'hFFB9) begin
			off = c - 32'hFFB1;
			code = off[7:0] + 8'h59;
		end else begin
			case (c)
				32'h21: code = 8'h1E;
				32'h40: code = 8'h1F;
				32'h23: code = 8'h20;
				32'h24: code = 8'h21;
				32'h25: code = 8'h22;
				32'h5E: code = 8'h23;
				32'h26: code = 8'h24;
				32'h2A: code = 8'h25;
				32'h28: code = 8'h26;
				32'h30, 32'h29: code = 8'h27;
				32'hFF0D: code = 8'h28;
				32'hFF1B: code = 8'h29;
				32'hFF08: code = 8'h2A;
				32'hFF09: code = 8'h2B;
				32'h20: code = 8'h2C;
				32'h2D, 32'h5F: code = 8'h2D;
				32'h3D, 32'h2B: code = 8'h2E;
				32'h5B, 32'h7B: code = 8'h2F;
				32'h5D, 32'h7D: code = 8'h30;
				32'h5C, 32'h7C: code = 8'h31;
				32'h3B, 32'h3A: code = 8'h33;
				32'h27, 32'h22: code = 8'h34;
				32'h60, 32'h7E: code = 8'h35;
				32'h2C, 32'h3C: code = 8'h36;
				32'h2E, 32'h3E: code = 8'h37;
				32'h2F, 32'h3F: code = 8'h38;
				32'hFF02: code = 8'h48;
				32'hFF6A: code = 8'h49;
				32'hFF50: code = 8'h4A;
				32'hFF55: code = 8'h4B;
				32'hFFFF: code = 8'h4C;
				32'hFF57: code = 8'h4D;
				32'hFF56: code = 8'h4E;
				32'hFF53: code = 8'h4F;
				32'hFF51: code = 8'h50;
				32'hFF54: code = 8'h51;
				32'hFF52: code = 8'h52;
				32'hFFAF: code = 8'h54;
				32'hFFAA: code = 8'h55;
				32'hFFAD: code = 8'h56;
				32'hFFAB: code = 8'h57;
				32'hFF8D: code = 8'h58;
				32'hFFB0: code = 8'h62;
				32'hFFAE: code = 8'h63;
				default: code = 8'h00;
			endcase
		end
		return code;
	endfunction

	task automatic report_error(input string msg);
		if (error_total < 50)
			$display("%0t ns: %s", $time, msg);
		error_total++;
	endtask

	task automatic apply_key_event(input logic down, input logic [31:0] k);
		logic [7:0]                mask;
		logic [7:0]                code;
		logic [7:0]                mods;
		logic [KEY_SLOTS-1:0][7:0] slots;
		logic                      placed;
		hid_report_t               next_report;
		mask = modifier_mask_for(k);
		code = hid_usage_for(k);
		mods = held_mods;
		slots = held_slots;
		if (mask != 8'h00) begin
			if (down) begin
				mods = mods | mask;
				if ((mods & BothShifts) == BothShifts) begin
					mods = 8'h00;
					slots = '0;
				end
			end else begin
				mods = mods & ~mask;
			end
		end
		if (code != 8'h00) begin
			if (down) begin
				placed = 1'b0;
				for (int i = 0; i < KEY_SLOTS; i++)
					if (slots[i] == code)
						placed = 1'b1;
				for (int i = 0; i < KEY_SLOTS; i++) begin
					if (!placed && slots[i] == 8'h00) begin
						slots[i] = code;
						placed = 1'b1;
					end
				end
			end else begin
				for (int i = 0; i < KEY_SLOTS; i++)
					if (slots[i] == code)
						slots[i] = 8'h00;
			end
		end
		if (mods != held_mods || slots != held_slots) begin
			held_mods = mods;
			held_slots = slots;
			next_report.mods = mods;
			next_report.first_code = slots[0];
			pending_reports.push_back(next_report);
		end
	endtask

	task automatic check_report();
		hid_report_t want;
		if (pending_reports.size() == 0) begin
			report_error($sformatf("report mods=%02h key=%02h with none expected",
				modifier_bits, first_key_code));
		end else begin
			want = pending_reports.pop_front();
			if (modifier_bits !== want.mods)
				report_error($sformatf("modifier_bits got %02h want %02h",
					modifier_bits, want.mods));
			if (first_key_code !== want.first_code)
				report_error($sformatf("first_key_code got %02h want %02h",
					first_key_code, want.first_code));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_report();
			if (in_valid && in_ready)
				apply_key_event(key_pressed, keysym);
			pending_total = pending_reports.size();
		end
	end

endmodule

[bench/keysym_to_hid_keyboard_report_test.sv]
`timescale 1ns / 1ps

module keysym_to_hid_keyboard_report_test;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        key_pressed = 1'b0;
	logic [31:0] keysym = 32'h0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [7:0]  modifier_bits;
	logic [7:0]  first_key_code;
	int          fail_count;
	int          open_count;

	logic [31:0] nav_keys [16] = '{
		32'hFF0D, 32'hFF1B, 32'hFF08, 32'hFF09, 32'hFF02, 32'hFF6A, 32'hFF50, 32'hFF55,
		32'hFFFF, 32'hFF57, 32'hFF56, 32'hFF53, 32'hFF51, 32'hFF54, 32'hFF52, 32'hFF8D
	};
	logic [31:0] held_keys[$];

	keysym_to_hid_keyboard_report dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.key_pressed    (key_pressed),
		.keysym         (keysym),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.modifier_bits  (modifier_bits),
		.first_key_code (first_key_code)
	);

	keysym_to_hid_keyboard_report_check check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.key_pressed    (key_pressed),
		.keysym         (keysym),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.modifier_bits  (modifier_bits),
		.first_key_code (first_key_code),
		.fail_count     (fail_count),
		.open_count     (open_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#8_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [31:0] pick_keysym();
		case ($urandom_range(0, 7))
			0, 1, 2: return $urandom_range(32'h20, 32'h7E);
			3: return $urandom_range(32'hFFE1, 32'hFFEA);
			4: return $urandom_range(32'hFFAA, 32'hFFCA);
			5: return nav_keys[$urandom_range(0, 15)];
			6: return $urandom_range(32'h41, 32'h5A);
			default: return $urandom_range(32'h61, 32'h7A);
		endcase
	endfunction

	task automatic send_key(input logic pressed, input logic [31:0] k);
		@(negedge clk);
		in_valid <= 1'b1;
		key_pressed <= pressed;
		keysym <= k;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic idle(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// receiver: random stall patterns, with a long hold-off now and then
	initial begin
		int         mode;
		int         span;
		int         tick;
		int         blk;
		logic [7:0] pattern;
		tick = 0;
		blk = 0;
		pattern = 8'b1011_0110;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 120);
			repeat (span) begin
				@(negedge clk);
				tick++;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= ($urandom_range(0, 1) == 0);
					default: out_ready <= pattern[tick % 8];
				endcase
			end
			blk++;
			if (blk == 3 || $urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(50, 100)) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
			end
		end
	end

	initial begin
		int          sent;
		int          burst;
		int          choice;
		int          idx;
		int          drain;
		logic [31:0] k;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// all modifiers, then both shifts clear the report
		send_key(1'b1, 32'hFFE3);
		send_key(1'b1, 32'hFFE9);
		send_key(1'b1, 32'hFFE7);
		send_key(1'b1, 32'hFFE4);
		send_key(1'b1, 32'hFFEA);
		send_key(1'b1, 32'hFFE8);
		send_key(1'b1, 32'hFFE1);
		send_key(1'b1, 32'hFFE2);
		// shifted letter over an already present key
		send_key(1'b1, 32'h61);
		send_key(1'b1, 32'h41);
		send_key(1'b0, 32'h41);
		// fill every slot, then overflow
		send_key(1'b1, 32'h31);
		send_key(1'b1, 32'hFFBE);
		send_key(1'b1, 32'hFFB9);
		send_key(1'b1, 32'hFF0D);
		send_key(1'b1, 32'h20);
		send_key(1'b1, 32'hFFFF);
		send_key(1'b1, 32'h7A);
		send_key(1'b1, 32'h7C);
		// unmapped keysyms at the extremes
		send_key(1'b1, 32'hFFFF_FFFF);
		send_key(1'b1, 32'h0000_0000);
		send_key(1'b0, 32'h31);
		send_key(1'b0, 32'h8000_0061);
		send_key(1'b0, 32'hFF0D);
		send_key(1'b0, 32'h7C);
		idle(4);

		sent = 0;
		while (sent < 1450) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				choice = $urandom_range(0, 99);
				if (choice < 45 && held_keys.size() < 9) begin
					k = pick_keysym();
					held_keys.push_back(k);
					send_key(1'b1, k);
					sent++;
				end else if (choice < 85 && held_keys.size() > 0) begin
					idx = $urandom_range(0, held_keys.size() - 1);
					k = held_keys[idx];
					held_keys.delete(idx);
					send_key(1'b0, k);
					sent++;
				end else begin
					case ($urandom_range(0, 2))
						0: k = $urandom();
						1: k = pick_keysym() | ($urandom_range(1, 32'hFFFF) << 16);
						default: k = pick_keysym();
					endcase
					send_key(1'($urandom_range(0, 1)), k);
					sent++;
				end
			end
			if ($urandom_range(0, 3) != 0)
				idle($urandom_range(1, 8));
		end
		idle(1);

		drain = 0;
		while (open_count != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (10) @(posedge clk);
		if (fail_count == 0 && open_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
